### src/ssbf_pkg.sv
`default_nettype none
package ssbf_pkg;

	localparam int MODE_W      = 2;
	localparam int CNT_IN_W    = 2;
	localparam int RANK_W      = 3;
	localparam int LANE_W      = 16;
	localparam int LANES       = 4;
	localparam int HANDLE_IN_W = 32;
	localparam int DIST_W      = 19;

	localparam int ENTRIES_DEF     = 16;
	localparam int MAX_INPUTS_DEF  = 2;
	localparam int MAX_DIMS_DEF    = 4;
	localparam int DIM_BITS_DEF    = 16;
	localparam int HANDLE_BITS_DEF = 32;

	// s_tuser opcodes
	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EXACT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

	// input tdata layout: handle, input_count, rank_first, rank_second, dims_first, dims_second
	localparam int IN_TDATA_W = HANDLE_IN_W + CNT_IN_W + 2 * RANK_W + 2 * LANES * LANE_W;

endpackage
`default_nettype wire

### src/ssbf_ram.sv
`default_nettype none
module ssbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### src/shape_signature_best_fit_cache.sv
`default_nettype none
// Shape signature cache with exact and best-fit lookup. Each input transaction
// carries one operation in s_tuser (put, exact lookup, best-fit lookup, clear)
// and gives exactly one result transaction. Signatures live in a simple
// dual-port RAM, one word per slot; put, exact and best-fit lookups sweep the
// RAM one slot per cycle, then pass the registered read data through one compare
// stage, the accumulate step and the write-back/result state. The next
// transaction is accepted once the block is back in idle, while the result is
// presented. Clear touches only the valid bits and the entry count; it skips the
// sweep and goes straight to the write-back/result state. Slot valid bits are
// flip-flops cleared by reset, so no clearing pass is needed. A result waits in
// the output register; a new operation is taken while it waits and stalls only
// at its own write-back.
module shape_signature_best_fit_cache #(
	parameter int ENTRIES     = ssbf_pkg::ENTRIES_DEF,
	parameter int MAX_INPUTS  = ssbf_pkg::MAX_INPUTS_DEF,
	parameter int MAX_DIMS    = ssbf_pkg::MAX_DIMS_DEF,
	parameter int DIM_BITS    = ssbf_pkg::DIM_BITS_DEF,
	parameter int HANDLE_BITS = ssbf_pkg::HANDLE_BITS_DEF,
	parameter int CNT_W       = $clog2(ENTRIES + 1),
	parameter int OUT_BITS    = 2 + ssbf_pkg::HANDLE_IN_W + ssbf_pkg::DIST_W + CNT_W,
	parameter int OUT_TW      = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// handle, input_count, rank_first, rank_second, dims_first, dims_second
	input  wire logic [ssbf_pkg::IN_TDATA_W-1:0] s_tdata,
	// mode
	input  wire logic [ssbf_pkg::MODE_W-1:0]     s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// found, hit_handle, distance, entry_count, table_full, zero pad
	output logic      [OUT_TW-1:0]               m_tdata
);
	import ssbf_pkg::*;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RNK_VW = MAX_INPUTS * RANK_W;
	localparam int DIM_VW = MAX_INPUTS * MAX_DIMS * DIM_BITS;
	localparam int WORD_W = CNT_IN_W + RNK_VW + DIM_VW + HANDLE_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FIN} state_t;
	typedef logic [MAX_INPUTS-1:0][RANK_W-1:0] ranks_t;
	typedef logic [MAX_INPUTS-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] dims_t;

	// input unpacking
	logic [HANDLE_IN_W-1:0]    in_handle;
	logic [CNT_IN_W-1:0]       in_cnt;
	logic [1:0][RANK_W-1:0]    in_rank;
	logic [1:0][LANES*LANE_W-1:0] in_lanes;

	assign in_handle   = s_tdata[HANDLE_IN_W-1:0];
	assign in_cnt      = s_tdata[HANDLE_IN_W +: CNT_IN_W];
	assign in_rank[0]  = s_tdata[HANDLE_IN_W + CNT_IN_W +: RANK_W];
	assign in_rank[1]  = s_tdata[HANDLE_IN_W + CNT_IN_W + RANK_W +: RANK_W];
	assign in_lanes[0] = s_tdata[HANDLE_IN_W + CNT_IN_W + 2 * RANK_W +: LANES * LANE_W];
	assign in_lanes[1] = s_tdata[HANDLE_IN_W + CNT_IN_W + 2 * RANK_W + LANES * LANE_W +:
		LANES * LANE_W];

	// normalized signature of the incoming transaction
	logic [CNT_IN_W-1:0]    n_cnt;
	ranks_t                 n_ranks;
	dims_t                  n_dims;
	logic [HANDLE_BITS-1:0] n_handle;

	always_comb begin
		logic [RANK_W-1:0] r;
		logic [LANE_W-1:0] lane;
		logic [63:0]       h64;
		n_cnt = (in_cnt > CNT_IN_W'(MAX_INPUTS)) ? CNT_IN_W'(MAX_INPUTS) : in_cnt;
		for (int i = 0; i < MAX_INPUTS; i++) begin
			r = (in_rank[i] > RANK_W'(MAX_DIMS)) ? RANK_W'(MAX_DIMS) : in_rank[i];
			n_ranks[i] = (CNT_IN_W'(i) < n_cnt) ? r : '0;
			for (int d = 0; d < MAX_DIMS; d++) begin
				lane = in_lanes[i][LANE_W*d +: LANE_W];
				n_dims[i][d] = (RANK_W'(d) < n_ranks[i]) ? lane[DIM_BITS-1:0] : '0;
			end
		end
		h64 = 64'(in_handle);
		n_handle = h64[HANDLE_BITS-1:0];
	end

	// latched query
	logic [MODE_W-1:0]      mode_q;
	logic [CNT_IN_W-1:0]    k_cnt_q;
	ranks_t                 k_ranks_q;
	dims_t                  k_dims_q;
	logic [HANDLE_BITS-1:0] k_handle_q;

	// control
	state_t             state_q;
	logic [IDX_W-1:0]   addr_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;
	logic               v_s1, last_s1, v_s2, last_s2;
	logic [IDX_W-1:0]   idx_s1, idx_s2;

	// scan accumulators
	logic                   found_q, free_q;
	logic [IDX_W-1:0]       hit_idx_q, free_idx_q;
	logic [HANDLE_BITS-1:0] hit_handle_q;
	logic [DIST_W-1:0]      best_q;

	// output register
	logic                   o_valid_q, o_found_q, o_full_q;
	logic [HANDLE_IN_W-1:0] o_hit_q;
	logic [DIST_W-1:0]      o_dist_q;
	logic [CNT_W-1:0]       o_count_q;

	// RAM
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	ssbf_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	logic [CNT_IN_W-1:0]    e_cnt;
	ranks_t                 e_ranks;
	dims_t                  e_dims;
	logic [HANDLE_BITS-1:0] e_handle;

	assign e_cnt    = ram_rdata[CNT_IN_W-1:0];
	assign e_ranks  = ram_rdata[CNT_IN_W +: RNK_VW];
	assign e_dims   = ram_rdata[CNT_IN_W + RNK_VW +: DIM_VW];
	assign e_handle = ram_rdata[CNT_IN_W + RNK_VW + DIM_VW +: HANDLE_BITS];

	// compare stage
	logic                   valid_s2, eq_s2, fit_s2;
	dims_t                  diff_s2;
	logic [HANDLE_BITS-1:0] handle_s2;

	always_ff @(posedge clk) begin
		logic ge;
		logic same;
		if (v_s1) begin
			ge = 1'b1;
			for (int i = 0; i < MAX_INPUTS; i++) begin
				for (int d = 0; d < MAX_DIMS; d++) begin
					ge = ge & (e_dims[i][d] >= k_dims_q[i][d]);
					diff_s2[i][d] <= e_dims[i][d] - k_dims_q[i][d];
				end
			end
			same = valid_q[idx_s1] && (e_cnt == k_cnt_q) && (e_ranks == k_ranks_q);
			valid_s2  <= valid_q[idx_s1];
			eq_s2     <= same && (e_dims == k_dims_q);
			fit_s2    <= same && ge;
			handle_s2 <= e_handle;
			idx_s2    <= idx_s1;
		end
	end

	// sum stage, folded into the accumulators
	logic [DIST_W-1:0] sum_s2;
	logic              hit_upd, free_upd;

	always_comb begin
		sum_s2 = '0;
		for (int i = 0; i < MAX_INPUTS; i++) begin
			for (int d = 0; d < MAX_DIMS; d++) begin
				sum_s2 = sum_s2 + DIST_W'(diff_s2[i][d]);
			end
		end
	end

	always_comb begin
		hit_upd = 1'b0;
		case (mode_q)
			MODE_PUT, MODE_EXACT: hit_upd = v_s2 && eq_s2 && !found_q;
			MODE_BEST:            hit_upd = v_s2 && fit_s2 && (!found_q || sum_s2 < best_q);
			default:              hit_upd = 1'b0;
		endcase
		free_upd = v_s2 && (mode_q == MODE_PUT) && !valid_s2 && !free_q;
	end

	// write-back / result
	logic             fin_go, put_new;
	logic [CNT_W-1:0] new_count;

	assign fin_go    = (state_q == ST_FIN) && (!o_valid_q || m_tready);
	assign put_new   = (mode_q == MODE_PUT) && !found_q && free_q;
	assign new_count = (mode_q == MODE_CLEAR) ? '0 : count_q + CNT_W'(put_new);
	assign ram_we    = fin_go && (mode_q == MODE_PUT) && (found_q || free_q);
	assign ram_waddr = found_q ? hit_idx_q : free_idx_q;
	assign ram_wdata = {k_handle_q, k_dims_q, k_ranks_q, k_cnt_q};
	assign ram_re    = (state_q == ST_SCAN);
	assign s_tready  = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q     <= s_tuser;
			k_cnt_q    <= n_cnt;
			k_ranks_q  <= n_ranks;
			k_dims_q   <= n_dims;
			k_handle_q <= n_handle;
		end
		if (ram_re) begin
			idx_s1 <= addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic [63:0] h64;
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			valid_q      <= '0;
			count_q      <= '0;
			v_s1         <= 1'b0;
			last_s1      <= 1'b0;
			v_s2         <= 1'b0;
			last_s2      <= 1'b0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
			hit_idx_q    <= '0;
			free_idx_q   <= '0;
			hit_handle_q <= '0;
			best_q       <= '0;
			o_valid_q    <= 1'b0;
			o_found_q    <= 1'b0;
			o_full_q     <= 1'b0;
			o_hit_q      <= '0;
			o_dist_q     <= '0;
			o_count_q    <= '0;
		end else begin
			v_s1    <= ram_re;
			last_s1 <= ram_re && (addr_q == LAST_IDX);
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (hit_upd) begin
				found_q      <= 1'b1;
				hit_idx_q    <= idx_s2;
				hit_handle_q <= handle_s2;
				best_q       <= sum_s2;
			end
			if (free_upd) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s2;
			end
			if (o_valid_q && m_tready && !fin_go) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						addr_q       <= '0;
						found_q      <= 1'b0;
						free_q       <= 1'b0;
						hit_handle_q <= '0;
						best_q       <= '0;
						state_q      <= (s_tuser == MODE_CLEAR) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + IDX_W'(1);
					if (addr_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s2 && last_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						h64 = 64'(hit_handle_q);
						o_valid_q <= 1'b1;
						o_found_q <= found_q && (mode_q != MODE_CLEAR);
						o_hit_q   <= (found_q && (mode_q != MODE_CLEAR)) ?
							h64[HANDLE_IN_W-1:0] : '0;
						o_dist_q  <= (mode_q == MODE_BEST) ? best_q : '0;
						o_full_q  <= (mode_q == MODE_PUT) && !found_q && !free_q;
						o_count_q <= new_count;
						count_q   <= new_count;
						if (mode_q == MODE_CLEAR) begin
							valid_q <= '0;
						end else if (put_new) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = OUT_TW'({o_full_q, o_count_q, o_dist_q, o_hit_q, o_found_q});

	// occupancy counter tracks the valid bits
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_q)))
		else $error("entry count out of step with valid bits");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count above table size");

	// a new transaction only starts with the compare pipeline empty
	a_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!v_s1 && !v_s2))
		else $error("transaction accepted while sweep still in flight");

	a_hit_or_full: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q |-> !(o_found_q && o_full_q))
		else $error("result flags both a hit and a full table");

	a_write_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (!v_s1 && !v_s2 && !ram_re))
		else $error("slot write overlaps the sweep");

endmodule
`default_nettype wire
